// ===== rtl/bole_pkg.sv =====
package bole_pkg;

    // Operation codes carried in the low bits of the input tdata.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
    localparam logic [OP_W-1:0] OP_INSERT     = 4'd4;
    localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
    localparam logic [OP_W-1:0] OP_READ       = 4'd6;
    localparam logic [OP_W-1:0] OP_SEARCH     = 4'd7;
    localparam logic [OP_W-1:0] OP_REVERSE    = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd9;

    // Result status codes.
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

// ===== rtl/bole_cell.sv =====
module bole_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  bole_pkg::t_cell_cmd   i_cmd,
    input  logic [CNT_W-1:0]      i_k,
    input  logic [DATA_WIDTH-1:0] i_v,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]      i_fill,
    input  logic                  i_below_hit,
    input  logic                  i_above_hit,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_sel_data,
    output logic                  o_below_hit,
    output logic                  o_above_hit,
    output logic [CNT_W-1:0]      o_first_idx,
    output logic [CNT_W-1:0]      o_last_idx
);
    import bole_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_mine;

    // Open a gap at the target cell or close the gap left by a removal.
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (IDX == i_k) begin
                n_data = i_v;
            end else if (IDX > i_k) begin
                n_data = i_prev_data;
            end
        end else if (i_cmd.rem) begin
            if (IDX >= i_k) begin
                n_data = i_next_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Match flags ripple up and down the chain to find the outermost hits.
    assign w_mine      = (r_data == i_key) && (IDX < i_fill);
    assign o_below_hit = i_below_hit | w_mine;
    assign o_above_hit = i_above_hit | w_mine;
    assign o_first_idx = (w_mine && !i_below_hit) ? IDX : '0;
    assign o_last_idx  = (w_mine && !i_above_hit) ? IDX : '0;

    assign o_data     = r_data;
    assign o_sel_data = (IDX == i_k) ? r_data : '0;

endmodule

// ===== rtl/bounded_ordered_list_engine_unit.sv =====
// Bounded ordered list of up to CAPACITY values held in a chain of cells,
// one value per cell. Every operation (push, pop, insert, remove, read,
// search, reverse, clear) takes effect at its transfer: the cells shift
// toward or away from the target position in parallel, match flags ripple
// along the chain for a search, and reverse only toggles an orientation
// flag that maps logical to physical positions. The block takes one item
// per clock; its result is loaded into the output register at the
// transfer and a new item is taken while that result waits as long as the
// downstream side takes it in the same cycle. Entries hold no defined value
// after reset and need no clearing pass: only entries below the count are
// ever read.
module bounded_ordered_list_engine_unit #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Fields from bit 0: op, value_in, pos.
    input  logic [((bole_pkg::OP_W + DATA_WIDTH + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                                 s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: value_out, found, found_pos, count, status.
    output logic [((DATA_WIDTH + 1 + $clog2(CAPACITY) + $clog2(CAPACITY + 1)
                   + bole_pkg::ST_W + 7) / 8) * 8 - 1:0]
                                 m_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready
);
    import bole_pkg::*;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int IN_BITS = OP_W + DATA_WIDTH + CNT_W;
    localparam int OUT_BITS = DATA_WIDTH + 1 + IDX_W + CNT_W + ST_W;
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    logic [OP_W-1:0]       w_op;
    logic [DATA_WIDTH-1:0] w_v;
    logic [CNT_W-1:0]      w_pos;

    logic [CNT_W-1:0]      r_fill, n_fill;
    logic                  r_rev, n_rev;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out, n_out;

    logic                  w_accept;
    logic                  w_full, w_empty;
    logic [CNT_W-1:0]      w_a_ins, w_a_rem, w_l_ins, w_l_rem;
    logic [CNT_W-1:0]      w_p_ins, w_p_rem, w_k;
    t_cell_cmd             w_cmd;
    logic                  w_is_ins;

    logic [DATA_WIDTH-1:0] w_data     [CAPACITY];
    logic [DATA_WIDTH-1:0] w_prev     [CAPACITY];
    logic [DATA_WIDTH-1:0] w_next     [CAPACITY];
    logic [DATA_WIDTH-1:0] w_sel_data [CAPACITY];
    logic [CNT_W-1:0]      w_first    [CAPACITY];
    logic [CNT_W-1:0]      w_last     [CAPACITY];
    logic                  w_below    [CAPACITY+1];
    logic                  w_above    [CAPACITY+1];

    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [CNT_W-1:0]      w_first_idx, w_last_idx, w_fpos;

    // Input unpacking.
    assign w_op  = s_axis_tdata[OP_W-1:0];
    assign w_v   = s_axis_tdata[OP_W+DATA_WIDTH-1:OP_W];
    assign w_pos = s_axis_tdata[IN_BITS-1:OP_W+DATA_WIDTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_full  = (r_fill == CAP);
    assign w_empty = (r_fill == '0);

    // Clamp positions and map logical positions onto the physical chain.
    assign w_a_ins = (w_pos > r_fill) ? r_fill : w_pos;
    assign w_a_rem = (w_pos >= r_fill) ? (r_fill - ONE) : w_pos;

    always_comb begin
        case (w_op)
            OP_PUSH_FRONT: w_l_ins = '0;
            OP_PUSH_BACK:  w_l_ins = r_fill;
            default:       w_l_ins = w_a_ins;
        endcase
        case (w_op)
            OP_POP_FRONT: w_l_rem = '0;
            OP_POP_BACK:  w_l_rem = r_fill - ONE;
            default:      w_l_rem = w_a_rem;
        endcase
    end

    assign w_p_ins  = r_rev ? (r_fill - w_l_ins) : w_l_ins;
    assign w_p_rem  = r_rev ? (r_fill - ONE - w_l_rem) : w_l_rem;
    assign w_is_ins = (w_op == OP_PUSH_FRONT) || (w_op == OP_PUSH_BACK) ||
                      (w_op == OP_INSERT);
    assign w_k      = w_is_ins ? w_p_ins : w_p_rem;

    // Chain of cells.
    assign w_below[0]        = 1'b0;
    assign w_above[CAPACITY] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = w_data[g];
        end else begin : g_mid
            assign w_prev[g] = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next[g] = w_data[g];
        end else begin : g_body
            assign w_next[g] = w_data[g+1];
        end

        bole_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_k         (w_k),
            .i_v         (w_v),
            .i_prev_data (w_prev[g]),
            .i_next_data (w_next[g]),
            .i_key       (w_v),
            .i_fill      (r_fill),
            .i_below_hit (w_below[g]),
            .i_above_hit (w_above[g+1]),
            .o_data      (w_data[g]),
            .o_sel_data  (w_sel_data[g]),
            .o_below_hit (w_below[g+1]),
            .o_above_hit (w_above[g]),
            .o_first_idx (w_first[g]),
            .o_last_idx  (w_last[g])
        );
    end

    // Collect the selected entry and the outermost match indexes.
    always_comb begin
        w_rd_data   = '0;
        w_first_idx = '0;
        w_last_idx  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_data   = w_rd_data | w_sel_data[i];
            w_first_idx = w_first_idx | w_first[i];
            w_last_idx  = w_last_idx | w_last[i];
        end
    end

    assign w_fpos = r_rev ? (r_fill - ONE - w_last_idx) : w_first_idx;

    // Operation decode: cell command, next count and orientation, result.
    always_comb begin
        logic [DATA_WIDTH-1:0] vout;
        logic                  fnd;
        logic [IDX_W-1:0]      fpos;
        logic [ST_W-1:0]       st;
        vout   = '0;
        fnd    = 1'b0;
        fpos   = '0;
        st     = ST_OK;
        n_fill = r_fill;
        n_rev  = r_rev;
        w_cmd  = '0;
        case (w_op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                if (w_full) begin
                    st = ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_fill    = r_fill + ONE;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE, OP_READ: begin
                if (w_empty) begin
                    st = ST_EMPTY;
                end else begin
                    if (w_op != OP_REMOVE) begin
                        vout = w_rd_data;
                    end
                    if (w_op != OP_READ) begin
                        w_cmd.rem = 1'b1;
                        n_fill    = r_fill - ONE;
                    end
                end
            end
            OP_SEARCH: begin
                fnd = w_below[CAPACITY];
                if (fnd) begin
                    fpos = w_fpos[IDX_W-1:0];
                end
            end
            OP_REVERSE: begin
                n_rev = !r_rev;
            end
            OP_CLEAR: begin
                n_fill = '0;
                n_rev  = 1'b0;
            end
            default: begin
            end
        endcase
        if (!w_accept) begin
            w_cmd = '0;
        end
        n_out = {st, n_fill, fpos, fnd, vout};
    end

    // List state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_rev  <= 1'b0;
        end else if (w_accept) begin
            r_fill <= n_fill;
            r_rev  <= n_rev;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out);

endmodule

// ===== rtl/bole_checker.sv =====
module bole_checker #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic [((DATA_WIDTH + 1 + $clog2(CAPACITY) + $clog2(CAPACITY + 1)
                  + bole_pkg::ST_W + 7) / 8) * 8 - 1:0]
                m_axis_tdata,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    import bole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int FP_LO = DATA_WIDTH + 1;
    localparam int CN_LO = FP_LO + IDX_W;
    localparam int ST_LO = CN_LO + CNT_W;

    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_found;
    logic [IDX_W-1:0]      w_fpos;
    logic [CNT_W-1:0]      w_count;
    logic [ST_W-1:0]       w_status;

    assign w_value  = m_axis_tdata[DATA_WIDTH-1:0];
    assign w_found  = m_axis_tdata[DATA_WIDTH];
    assign w_fpos   = m_axis_tdata[CN_LO-1:FP_LO];
    assign w_count  = m_axis_tdata[ST_LO-1:CN_LO];
    assign w_status = m_axis_tdata[ST_LO+ST_W-1:ST_LO];

    // A refused push can only come from a list that is full.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == ST_FULL) |-> (w_count == CNT_W'(CAPACITY)))
        else $error("full status with a count below capacity");

    // An empty status leaves nothing in the list and reports no value.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == ST_EMPTY) |-> (w_count == '0) && (w_value == '0))
        else $error("empty status with entries or a value");

    // A search hit names an entry that exists.
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_found |->
            ({1'b0, w_fpos} < {1'b0, w_count}) && (w_status == ST_OK))
        else $error("search hit outside the list");

    // The count never passes capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_count <= CNT_W'(CAPACITY)))
        else $error("count above capacity");

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind bounded_ordered_list_engine_unit bole_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
) u_bole_checker (.*);

// ===== test/bounded_ordered_list_engine_unit_tb.sv =====
module bounded_ordered_list_engine_unit_tb;
    import bole_pkg::*;

    localparam int LIST_CAP    = 16;
    localparam int VAL_W       = 32;
    localparam int POS_W       = 5;
    localparam int IN_BITS     = OP_W + VAL_W + POS_W;
    localparam int OUT_BITS    = VAL_W + 1 + 4 + POS_W + ST_W;
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;
    localparam int RANDOM_OPS  = 1600;
    localparam int PHASE_LEN   = 40;
    localparam int STALL_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;

    // Op codes the block treats as no-ops.
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 4'd10;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 4'd15;

    // Bias of a random phase.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } t_mix;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic             drain;
    } t_list_cmd;

    typedef struct packed {
        logic [VAL_W-1:0] value_out;
        logic             found;
        logic [3:0]       found_pos;
        logic [POS_W-1:0] count;
        logic [ST_W-1:0]  status;
    } t_list_reply;

    logic              i_clk;
    logic              i_rst_n;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;

    // Commands waiting to be sent and replies waiting to be seen.
    t_list_cmd   pending_ops[$];
    t_list_reply awaited_replies[$];

    // Shadow copy of the list contents.
    logic [VAL_W-1:0] list_cells [LIST_CAP];
    int               list_fill;

    logic [VAL_W-1:0] value_pool [8];
    int               mismatch_cnt;
    int               stuck_cycles;

    bounded_ordered_list_engine_unit #(
        .CAPACITY   (LIST_CAP),
        .DATA_WIDTH (VAL_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        // Fields from bit 0: op, value_in, pos.
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // Fields from bit 0: value_out, found, found_pos, count, status.
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Apply one command to the shadow list and return the reply it produces.
    function automatic t_list_reply apply_list_op(input t_list_cmd c);
        t_list_reply      r;
        int               at;
        int               i;
        int               lo;
        int               hi;
        logic [VAL_W-1:0] t;
        r = '0;
        case (c.op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                if (list_fill >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    if (c.op == OP_PUSH_FRONT) at = 0;
                    else if (c.op == OP_PUSH_BACK) at = list_fill;
                    else at = (int'(c.pos) > list_fill) ? list_fill : int'(c.pos);
                    for (i = list_fill; i > at; i--) list_cells[i] = list_cells[i-1];
                    list_cells[at] = c.value;
                    list_fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE, OP_READ: begin
                if (list_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (c.op == OP_POP_FRONT) at = 0;
                    else if (c.op == OP_POP_BACK) at = list_fill - 1;
                    else at = (int'(c.pos) >= list_fill) ? list_fill - 1 : int'(c.pos);
                    // A remove reports zero rather than the value it drops.
                    if (c.op != OP_REMOVE) r.value_out = list_cells[at];
                    if (c.op != OP_READ) begin
                        for (i = at; i + 1 < list_fill; i++) list_cells[i] = list_cells[i+1];
                        list_fill--;
                    end
                end
            end
            OP_SEARCH: begin
                for (i = 0; i < list_fill; i++) begin
                    if (!r.found && list_cells[i] == c.value) begin
                        r.found     = 1'b1;
                        r.found_pos = 4'(i);
                    end
                end
            end
            OP_REVERSE: begin
                lo = 0;
                hi = list_fill - 1;
                while (lo < hi) begin
                    t              = list_cells[lo];
                    list_cells[lo] = list_cells[hi];
                    list_cells[hi] = t;
                    lo++;
                    hi--;
                end
            end
            OP_CLEAR: begin
                list_fill = 0;
            end
            default: begin
            end
        endcase
        r.count = POS_W'(list_fill);
        return r;
    endfunction

    // Idle length between transfers: mostly short, now and then long.
    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Values come often from a small pool so that searches find hits.
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return value_pool[$urandom_range(0, 7)];
        if (r < 50) return '0;
        if (r < 55) return '1;
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return POS_W'(LIST_CAP);
        if (r < 25) return '0;
        return POS_W'($urandom_range(0, LIST_CAP));
    endfunction

    function automatic logic [OP_W-1:0] pick_reserved_op();
        return OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (r < 35) return OP_PUSH_BACK;
                if (r < 55) return OP_PUSH_FRONT;
                if (r < 75) return OP_INSERT;
                if (r < 83) return OP_SEARCH;
                if (r < 90) return OP_READ;
                if (r < 94) return OP_POP_FRONT;
                if (r < 97) return OP_REVERSE;
                return OP_REMOVE;
            end
            MIX_SHRINK: begin
                if (r < 25) return OP_POP_FRONT;
                if (r < 50) return OP_POP_BACK;
                if (r < 70) return OP_REMOVE;
                if (r < 78) return OP_READ;
                if (r < 85) return OP_SEARCH;
                if (r < 90) return OP_REVERSE;
                if (r < 95) return OP_PUSH_BACK;
                return OP_INSERT;
            end
            default: begin
                if (r < 1) return OP_CLEAR;
                if (r < 2) return pick_reserved_op();
                if (r < 12) return OP_PUSH_FRONT;
                if (r < 24) return OP_PUSH_BACK;
                if (r < 34) return OP_POP_FRONT;
                if (r < 44) return OP_POP_BACK;
                if (r < 56) return OP_INSERT;
                if (r < 66) return OP_REMOVE;
                if (r < 78) return OP_READ;
                if (r < 92) return OP_SEARCH;
                return OP_REVERSE;
            end
        endcase
    endfunction

    function automatic t_list_cmd make_cmd(input logic [OP_W-1:0] op,
                                           input logic [VAL_W-1:0] value,
                                           input logic [POS_W-1:0] pos);
        t_list_cmd c;
        c.op    = op;
        c.value = value;
        c.pos   = pos;
        c.drain = 1'b0;
        return c;
    endfunction

    // Append one command to the send queue.
    function automatic void add_cmd(input t_list_cmd c);
        pending_ops.insert(pending_ops.size(), c);
    endfunction

    // Stimulus: directed corner cases, then random phases, then wait for the tail.
    initial begin
        t_list_cmd c;
        t_mix      mix;
        int        n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        list_fill     = 0;
        mismatch_cnt  = 0;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (n = 2; n < 8; n++) value_pool[n] = $urandom;

        // Empty list behavior, then the clamped positions on a short list.
        add_cmd(make_cmd(OP_POP_FRONT, '1, '0));
        add_cmd(make_cmd(OP_POP_BACK, '0, '1));
        add_cmd(make_cmd(OP_REMOVE, '0, POS_W'(LIST_CAP)));
        add_cmd(make_cmd(OP_READ, '0, '0));
        add_cmd(make_cmd(OP_SEARCH, '0, '0));
        add_cmd(make_cmd(OP_REVERSE, '0, '0));
        add_cmd(make_cmd(OP_RESERVED_HI, '1, '1));
        add_cmd(make_cmd(OP_PUSH_BACK, '0, '0));
        add_cmd(make_cmd(OP_PUSH_FRONT, '1, '0));
        add_cmd(make_cmd(OP_INSERT, 32'h1234_5678, POS_W'(LIST_CAP)));
        add_cmd(make_cmd(OP_INSERT, 32'hA5A5_A5A5, 5'd1));
        add_cmd(make_cmd(OP_INSERT, 32'h5A5A_5A5A, '0));
        add_cmd(make_cmd(OP_READ, '0, POS_W'(LIST_CAP)));
        add_cmd(make_cmd(OP_SEARCH, '1, '0));
        add_cmd(make_cmd(OP_SEARCH, 32'h0BAD_F00D, '0));
        add_cmd(make_cmd(OP_REVERSE, '0, '0));
        add_cmd(make_cmd(OP_READ, '0, '0));
        add_cmd(make_cmd(OP_REMOVE, '0, POS_W'(LIST_CAP)));
        add_cmd(make_cmd(OP_REMOVE, '0, '0));
        add_cmd(make_cmd(OP_POP_BACK, '0, '0));
        add_cmd(make_cmd(OP_POP_FRONT, '0, '0));
        add_cmd(make_cmd(OP_PUSH_BACK, 32'd7, '0));
        add_cmd(make_cmd(OP_POP_BACK, '0, '0));
        add_cmd(make_cmd(OP_PUSH_BACK, 32'd9, '0));
        add_cmd(make_cmd(OP_CLEAR, '0, '0));

        // Random phases; the first one is biased toward growing the list.
        mix = MIX_GROW;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % PHASE_LEN == 0 && n != 0) begin
                mix = t_mix'($urandom_range(0, 2));
            end
            c = make_cmd(pick_op(mix), pick_value(), pick_pos());
            c.drain = (n == 0) || (n % PHASE_LEN == 0 && $urandom_range(0, 3) == 0);
            add_cmd(c);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || awaited_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && awaited_replies.size() == 0) begin
            $display("bounded_ordered_list_engine_unit_tb: done, clean");
        end else begin
            $display("bounded_ordered_list_engine_unit_tb: done, errors");
        end
        $finish;
    end

    // Driver: record each accepted transfer, then present the next command.
    int   send_gap;
    logic send_calm;
    initial begin
        send_gap  = 0;
        send_calm = 1'b0;
    end

    always @(posedge i_clk) begin
        logic      nxt_valid;
        t_list_cmd c;
        nxt_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                c = pending_ops[0];
                pending_ops.delete(0);
                awaited_replies.insert(awaited_replies.size(), apply_list_op(c));
                nxt_valid = 1'b0;
                send_gap  = pick_gap(send_calm);
                if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
            end
            if (!nxt_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (pending_ops.size() != 0 &&
                             !(pending_ops[0].drain && awaited_replies.size() != 0)) begin
                    nxt_valid = 1'b1;
                    c = pending_ops[0];
                    s_axis_tdata <= {{(IN_W - IN_BITS){1'b0}}, c.pos, c.value, c.op};
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // Monitor: compare each result transfer with the oldest awaited reply.
    int   sink_gap;
    logic sink_calm;
    initial begin
        sink_gap  = 0;
        sink_calm = 1'b0;
    end

    always @(posedge i_clk) begin
        t_list_reply want;
        t_list_reply got;
        logic        nxt_ready;
        nxt_ready = m_axis_tready;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.value_out = m_axis_tdata[VAL_W-1:0];
                got.found     = m_axis_tdata[VAL_W];
                got.found_pos = m_axis_tdata[VAL_W+4:VAL_W+1];
                got.count     = m_axis_tdata[VAL_W+4+POS_W:VAL_W+5];
                got.status    = m_axis_tdata[OUT_BITS-1:OUT_BITS-ST_W];
                if (awaited_replies.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("unexpected result: value %h found %b pos %0d count %0d st %0d",
                                 got.value_out, got.found, got.found_pos, got.count,
                                 got.status);
                end else begin
                    want = awaited_replies[0];
                    awaited_replies.delete(0);
                    if (got.value_out !== want.value_out || got.found !== want.found ||
                        got.found_pos !== want.found_pos || got.count !== want.count ||
                        got.status !== want.status) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX) begin
                            $display("mismatch expected: value %h found %b pos %0d count %0d st %0d",
                                     want.value_out, want.found, want.found_pos, want.count,
                                     want.status);
                            $display("         actual:   value %h found %b pos %0d count %0d st %0d",
                                     got.value_out, got.found, got.found_pos, got.count,
                                     got.status);
                        end
                    end
                end
                sink_gap = pick_gap(sink_calm);
                if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
            end
            if (sink_gap != 0) begin
                sink_gap--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        m_axis_tready <= nxt_ready;
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STALL_LIMIT) begin
            $display("bounded_ordered_list_engine_unit_tb: done, errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
